// ===== src/ctu2d_pkg.sv =====
// Shared constants and query kind codes of the 2D collision test unit.
package ctu2d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RAD_W          = 15;
  localparam int KIND_W         = 3;

  localparam logic [KIND_W-1:0] KIND_PT_CIRCLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CIRC_CIRC   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PT_SEG      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEG_SEG     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEG_CIRCLE  = 3'd4;

endpackage

// ===== src/collision_test_unit_2d_core.sv =====
// Top level of the 2D collision test unit: a six-stage pipeline of exact integer tests.
//
// Usage: one geometry query enters on the in_ channel per transfer (in_valid high,
// in_stall low at a rising edge); one result (out_hit, out_degenerate) leaves on
// the out_ channel per transfer. Results come out in query order.
// out_valid rises once a query has passed through every stage register, when the
// output is not stalled. Throughput is one query per cycle without out_stall:
// the stages are difference, product, sum, compare with partial products of the wide
// interior test, wide sum, and the output register, each with its own valid bit.
// When the receiver raises out_stall, the result is held in the output register
// and the stages behind it keep advancing until each holds an item; only then
// does in_stall rise. in_stall never rises while the output register is empty.
// Reset (rst_n low at a clock edge) empties every stage; no result is pending
// afterwards. The unit holds no state between queries.
module collision_test_unit_2d_core
  import ctu2d_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [COORD_BITS-1:0] in_a_x,
  input  logic [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-1:0] in_b_x,
  input  logic [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-1:0] in_c_x,
  input  logic [COORD_BITS-1:0] in_c_y,
  input  logic [COORD_BITS-1:0] in_d_x,
  input  logic [COORD_BITS-1:0] in_d_y,
  input  logic [RAD_W-1:0]      in_circle_radius,
  input  logic [RAD_W-1:0]      in_first_radius,
  input  logic [RAD_W-1:0]      in_second_radius,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic                  out_degenerate
);

  localparam int CB  = (COORD_BITS > 31) ? 31 : COORD_BITS;
  localparam int D   = CB + 1;
  localparam int P   = 2 * D;
  localparam int SW  = (2 * D + 1 > 33) ? 2 * D + 1 : 33;
  localparam int MW  = 2 * CB + 2;
  localparam int H   = CB + 1;
  localparam int LW  = 4 * H + 2 * RAD_W;
  localparam int R2W = 2 * RAD_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !out_valid || !out_stall;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // Stage 1: differences.
  logic signed [D-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = $signed({in_a_x[CB-1], in_a_x[CB-1:0]});
  assign ay = $signed({in_a_y[CB-1], in_a_y[CB-1:0]});
  assign bx = $signed({in_b_x[CB-1], in_b_x[CB-1:0]});
  assign by = $signed({in_b_y[CB-1], in_b_y[CB-1:0]});
  assign cx = $signed({in_c_x[CB-1], in_c_x[CB-1:0]});
  assign cy = $signed({in_c_y[CB-1], in_c_y[CB-1:0]});
  assign dx = $signed({in_d_x[CB-1], in_d_x[CB-1:0]});
  assign dy = $signed({in_d_y[CB-1], in_d_y[CB-1:0]});

  logic [KIND_W-1:0]   k1_r;
  logic signed [D-1:0] sx_r, sy_r, ex_r, ey_r, wx_r, wy_r, tx_r, ty_r, qx_r, qy_r;
  logic [RAD_W-1:0]    rc1_r;
  logic [RAD_W:0]      rs1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      k1_r  <= in_kind;
      sx_r  <= bx - ax;
      sy_r  <= by - ay;
      ex_r  <= (in_kind == KIND_PT_CIRCLE) ? cx - dx : dx - bx;
      ey_r  <= (in_kind == KIND_PT_CIRCLE) ? cy - dy : dy - by;
      wx_r  <= (in_kind == KIND_PT_SEG) ? cx - ax : dx - ax;
      wy_r  <= (in_kind == KIND_PT_SEG) ? cy - ay : dy - ay;
      tx_r  <= dx - cx;
      ty_r  <= dy - cy;
      qx_r  <= ax - cx;
      qy_r  <= ay - cy;
      rc1_r <= in_circle_radius;
      rs1_r <= {1'b0, in_first_radius} + {1'b0, in_second_radius};
    end
  end

  // Stage 2: products.
  logic [KIND_W-1:0]   k2_r;
  logic signed [P-1:0] sxx_r, syy_r, exx_r, eyy_r, wxx_r, wyy_r;
  logic signed [P-1:0] wysx_r, wxsy_r, wxsx_r, wysy_r;
  logic signed [P-1:0] tysx_r, txsy_r, txqy_r, tyqx_r, sxqy_r, syqx_r;
  logic [R2W-1:0]      rc2_r;
  logic [R2W+1:0]      rs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      k2_r   <= k1_r;
      sxx_r  <= sx_r * sx_r;
      syy_r  <= sy_r * sy_r;
      exx_r  <= ex_r * ex_r;
      eyy_r  <= ey_r * ey_r;
      wxx_r  <= wx_r * wx_r;
      wyy_r  <= wy_r * wy_r;
      wysx_r <= wy_r * sx_r;
      wxsy_r <= wx_r * sy_r;
      wxsx_r <= wx_r * sx_r;
      wysy_r <= wy_r * sy_r;
      tysx_r <= ty_r * sx_r;
      txsy_r <= tx_r * sy_r;
      txqy_r <= tx_r * qy_r;
      tyqx_r <= ty_r * qx_r;
      sxqy_r <= sx_r * qy_r;
      syqx_r <= sy_r * qx_r;
      rc2_r  <= rc1_r * rc1_r;
      rs2_r  <= rs1_r * rs1_r;
    end
  end

  // Stage 3: sums.
  logic [KIND_W-1:0]    k3_r;
  logic signed [SW-1:0] slen_r, lene_r, lenw_r, dot_r, cr_r, den_r, ua_r, ub_r;
  logic signed [SW-1:0] rc2s_r, rs2s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      k3_r   <= k2_r;
      slen_r <= SW'(sxx_r) + SW'(syy_r);
      lene_r <= SW'(exx_r) + SW'(eyy_r);
      lenw_r <= SW'(wxx_r) + SW'(wyy_r);
      dot_r  <= SW'(wxsx_r) + SW'(wysy_r);
      cr_r   <= SW'(wysx_r) - SW'(wxsy_r);
      den_r  <= SW'(tysx_r) - SW'(txsy_r);
      ua_r   <= SW'(txqy_r) - SW'(tyqx_r);
      ub_r   <= SW'(sxqy_r) - SW'(syqx_r);
      rc2s_r <= $signed(SW'(rc2_r));
      rs2s_r <= $signed(SW'(rs2_r));
    end
  end

  // Stage 4: comparisons and partial products of the interior test.
  logic [SW-1:0] cr_abs;
  logic [MW-1:0] crm, slm;
  logic          den_pos, ua_ok, ub_ok;

  assign cr_abs  = cr_r[SW-1] ? SW'(-cr_r) : SW'(cr_r);
  assign crm     = cr_abs[MW-1:0];
  assign slm     = slen_r[MW-1:0];
  assign den_pos = !den_r[SW-1];
  assign ua_ok   = den_pos ? (!ua_r[SW-1] && ua_r <= den_r) : (ua_r <= 0 && ua_r >= den_r);
  assign ub_ok   = den_pos ? (!ub_r[SW-1] && ub_r <= den_r) : (ub_r <= 0 && ub_r >= den_r);

  logic [KIND_W-1:0] k4_r;
  logic              zero4_r, den0_4_r, hit0_r, hit1_r, hit2_r, hit3_r, hit4s_r, wide4_r;
  logic [2*H-1:0]    pp_hh_r, pp_hl_r, pp_ll_r;
  logic [H+R2W-1:0]  qh_r, ql_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      k4_r     <= k3_r;
      zero4_r  <= slen_r == 0;
      den0_4_r <= den_r == 0;
      hit0_r   <= lene_r <= rc2s_r;
      hit1_r   <= slen_r <= rs2s_r;
      hit2_r   <= cr_r == 0 && !dot_r[SW-1] && dot_r <= slen_r;
      hit3_r   <= ua_ok && ub_ok;
      hit4s_r  <= (dot_r <= 0) ? (lenw_r <= rc2s_r) : (lene_r <= rc2s_r);
      wide4_r  <= dot_r > 0 && dot_r < slen_r;
      pp_hh_r  <= crm[MW-1:H] * crm[MW-1:H];
      pp_hl_r  <= crm[MW-1:H] * crm[H-1:0];
      pp_ll_r  <= crm[H-1:0] * crm[H-1:0];
      qh_r     <= slm[MW-1:H] * rc2s_r[R2W-1:0];
      ql_r     <= slm[H-1:0] * rc2s_r[R2W-1:0];
    end
  end

  // Stage 5: wide sums of the interior test.
  logic [KIND_W-1:0] k5_r;
  logic              zero5_r, den0_5_r, hit0_5_r, hit1_5_r, hit2_5_r, hit3_5_r;
  logic              hit4s_5_r, wide5_r;
  logic [LW-1:0]     lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
    if (en5) begin
      k5_r      <= k4_r;
      zero5_r   <= zero4_r;
      den0_5_r  <= den0_4_r;
      hit0_5_r  <= hit0_r;
      hit1_5_r  <= hit1_r;
      hit2_5_r  <= hit2_r;
      hit3_5_r  <= hit3_r;
      hit4s_5_r <= hit4s_r;
      wide5_r   <= wide4_r;
      lhs_r     <= (LW'(pp_hh_r) << (2 * H)) + (LW'(pp_hl_r) << (H + 1)) + LW'(pp_ll_r);
      rhs_r     <= (LW'(qh_r) << H) + LW'(ql_r);
    end
  end

  // Stage 6: output register.
  logic hit_nxt, deg_nxt;

  always_comb begin
    hit_nxt = 1'b0;
    deg_nxt = 1'b0;
    case (k5_r)
      KIND_PT_CIRCLE: hit_nxt = hit0_5_r;
      KIND_CIRC_CIRC: hit_nxt = hit1_5_r;
      KIND_PT_SEG: begin
        deg_nxt = zero5_r;
        hit_nxt = !zero5_r && hit2_5_r;
      end
      KIND_SEG_SEG: begin
        deg_nxt = den0_5_r;
        hit_nxt = !den0_5_r && hit3_5_r;
      end
      KIND_SEG_CIRCLE: begin
        deg_nxt = zero5_r;
        hit_nxt = !zero5_r && (wide5_r ? (lhs_r <= rhs_r) : hit4s_5_r);
      end
      default: begin
        hit_nxt = 1'b0;
        deg_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en6) begin
      out_valid <= v5_r;
    end
    if (en6) begin
      out_hit        <= hit_nxt;
      out_degenerate <= deg_nxt;
    end
  end

endmodule

// ===== src/ctu2d_checker.sv =====
// Port-level checker of the 2D collision test unit and its bind statement.
module ctu2d_checker
  import ctu2d_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit,
  input logic out_degenerate
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("A result is pending right after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("The input stalls without a stalled result at the output.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_degenerate))
    else $error("A stalled result changed or was dropped.");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_degenerate))
    else $error("A result is both a hit and degenerate.");

endmodule

bind collision_test_unit_2d_core ctu2d_checker u_ctu2d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_degenerate (out_degenerate)
);

// ===== tb/ctu2d_checker.sv =====
// Checker of the 2D collision test unit: predicts every query's hit and degenerate flags and compares.
module ctu2d_scoreboard
  import ctu2d_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [COORD_BITS-1:0] in_a_x,
  input  logic [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-1:0] in_b_x,
  input  logic [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-1:0] in_c_x,
  input  logic [COORD_BITS-1:0] in_c_y,
  input  logic [COORD_BITS-1:0] in_d_x,
  input  logic [COORD_BITS-1:0] in_d_y,
  input  logic [RAD_W-1:0]      in_circle_radius,
  input  logic [RAD_W-1:0]      in_first_radius,
  input  logic [RAD_W-1:0]      in_second_radius,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_hit,
  input  logic                  out_degenerate,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  typedef logic signed [63:0] wide_t;
  typedef struct packed {
    logic hit;
    logic degenerate;
  } verdict_t;

  verdict_t expected_verdicts[DEPTH];
  int put_total = 0;
  int take_total = 0;

  function automatic wide_t sq(wide_t v);
    return v * v;
  endfunction

  function automatic verdict_t judge_query(
    logic [KIND_W-1:0] kind,
    wide_t ax, wide_t ay, wide_t bx, wide_t by,
    wide_t cx, wide_t cy, wide_t dx, wide_t dy,
    wide_t rc, wide_t r1, wide_t r2);
    verdict_t v;
    wide_t sx, sy, slen, wx, wy, cr, dt, tx, ty, den, ua, ub, rr;
    logic signed [127:0] lhs, rhs;
    v = '0;
    sx = bx - ax;
    sy = by - ay;
    slen = sq(sx) + sq(sy);
    rr = rc * rc;
    case (kind)
      KIND_PT_CIRCLE: v.hit = (sq(cx - dx) + sq(cy - dy)) <= rr;
      KIND_CIRC_CIRC: v.hit = slen <= sq(r1 + r2);
      KIND_PT_SEG: begin
        if (slen == 0) begin
          v.degenerate = 1'b1;
        end else begin
          wx = cx - ax;
          wy = cy - ay;
          cr = wy * sx - wx * sy;
          dt = wx * sx + wy * sy;
          v.hit = cr == 0 && dt >= 0 && dt <= slen;
        end
      end
      KIND_SEG_SEG: begin
        tx = dx - cx;
        ty = dy - cy;
        den = ty * sx - tx * sy;
        if (den == 0) begin
          v.degenerate = 1'b1;
        end else begin
          ua = tx * (ay - cy) - ty * (ax - cx);
          ub = sx * (ay - cy) - sy * (ax - cx);
          if (den < 0) begin
            den = -den;
            ua = -ua;
            ub = -ub;
          end
          v.hit = ua >= 0 && ua <= den && ub >= 0 && ub <= den;
        end
      end
      KIND_SEG_CIRCLE: begin
        if (slen == 0) begin
          v.degenerate = 1'b1;
        end else begin
          wx = dx - ax;
          wy = dy - ay;
          dt = wx * sx + wy * sy;
          if (dt <= 0) begin
            v.hit = (sq(wx) + sq(wy)) <= rr;
          end else if (dt >= slen) begin
            v.hit = (sq(dx - bx) + sq(dy - by)) <= rr;
          end else begin
            cr = wx * sy - wy * sx;
            lhs = 128'(cr) * 128'(cr);
            rhs = 128'(rr) * 128'(slen);
            v.hit = lhs <= rhs;
          end
        end
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = put_total - take_total;

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && in_valid && !in_stall) begin
      expected_verdicts[6'(put_total)] = judge_query(in_kind,
        wide_t'($signed(in_a_x)), wide_t'($signed(in_a_y)),
        wide_t'($signed(in_b_x)), wide_t'($signed(in_b_y)),
        wide_t'($signed(in_c_x)), wide_t'($signed(in_c_y)),
        wide_t'($signed(in_d_x)), wide_t'($signed(in_d_y)),
        wide_t'(in_circle_radius), wide_t'(in_first_radius),
        wide_t'(in_second_radius));
      put_total++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (put_total == take_total) begin
        report_mismatch("result transfer with no query outstanding");
      end else begin
        want = expected_verdicts[6'(take_total)];
        take_total++;
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_hit, want.hit));
        if (out_degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %b, expected %b",
                                    out_degenerate, want.degenerate));
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the 2D collision test unit testbench: stimulus, flow control and verdict.
module testbench
  import ctu2d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [CW-1:0] in_a_x = '0, in_a_y = '0, in_b_x = '0, in_b_y = '0;
  logic [CW-1:0] in_c_x = '0, in_c_y = '0, in_d_x = '0, in_d_y = '0;
  logic [RAD_W-1:0] in_circle_radius = '0, in_first_radius = '0, in_second_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit, out_degenerate;
  int fail_count, pending_count;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  collision_test_unit_2d_core dut (.*);
  ctu2d_scoreboard checker_i (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[collision_test_unit_2d_core] ERROR");
      $finish;
    end
  end

  typedef logic [CW-1:0] coord_t;

  task automatic send_query(logic [KIND_W-1:0] kind, coord_t ax, coord_t ay,
                            coord_t bx, coord_t by, coord_t cx, coord_t cy,
                            coord_t dx, coord_t dy, logic [RAD_W-1:0] rc,
                            logic [RAD_W-1:0] r1, logic [RAD_W-1:0] r2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_a_x <= ax; in_a_y <= ay; in_b_x <= bx; in_b_y <= by;
    in_c_x <= cx; in_c_y <= cy; in_d_x <= dx; in_d_y <= dy;
    in_circle_radius <= rc; in_first_radius <= r1; in_second_radius <= r2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(16)) - 8);
      2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return coord_t'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic send_random_query();
    logic [KIND_W-1:0] kind;
    coord_t ax, ay, bx, by, cx, cy, dx, dy, k;
    logic [RAD_W-1:0] rc;
    kind = ($urandom_range(19) == 0) ? KIND_W'($urandom_range(7, 5))
                                     : KIND_W'($urandom_range(4));
    ax = pick_coord(); ay = pick_coord(); bx = pick_coord(); by = pick_coord();
    cx = pick_coord(); cy = pick_coord(); dx = pick_coord(); dy = pick_coord();
    rc = ($urandom_range(3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(300));
    case ($urandom_range(5))
      0: begin
        bx = ax; by = ay;
      end
      1: begin
        k = coord_t'($urandom_range(4));
        cx = ax + k * (bx - ax) / 3;
        cy = ay + k * (by - ay) / 3;
        dx = cx + (bx - ax);
        dy = cy + (by - ay);
      end
      2: begin
        k = coord_t'($urandom_range(6));
        cx = ax + k * coord_t'(3); cy = ay + k * coord_t'(2);
        bx = ax + coord_t'(12); by = ay + coord_t'(8);
      end
      default: ;
    endcase
    send_query(kind, ax, ay, bx, by, cx, cy, dx, dy, rc,
               RAD_W'($urandom), RAD_W'($urandom));
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_query();
    in_valid <= 1'b0;
  endtask

  initial begin
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_query(KIND_PT_CIRCLE, 0, 0, 0, 0, 3, 4, 0, 0, 5, 0, 0);
    send_query(KIND_PT_CIRCLE, 0, 0, 0, 0, mx, mx, mn, mn, '1, 0, 0);
    send_query(KIND_PT_CIRCLE, 0, 0, 0, 0, mn, mn, mx, mx, 0, 0, 0);
    send_query(KIND_CIRC_CIRC, mn, mn, mx, mx, 0, 0, 0, 0, 0, '1, '1);
    send_query(KIND_CIRC_CIRC, 0, 0, 10, 0, 0, 0, 0, 0, 0, 4, 6);
    send_query(KIND_PT_SEG, 0, 0, 10, 10, 5, 5, 0, 0, 0, 0, 0);
    send_query(KIND_PT_SEG, 0, 0, 10, 10, 11, 11, 0, 0, 0, 0, 0);
    send_query(KIND_PT_SEG, 7, 7, 7, 7, 7, 7, 0, 0, 0, 0, 0);
    send_query(KIND_PT_SEG, mn, mn, mx, mx, mx, mx, 0, 0, 0, 0, 0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, 0, 0, 0, 0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 0, 0, 5, 0, 0, 0, 0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 0, 1, 10, 1, 0, 0, 0);
    send_query(KIND_SEG_SEG, 0, 0, 0, 0, 1, 1, 2, 3, 0, 0, 0);
    send_query(KIND_SEG_SEG, mn, mn, mx, mx, mn, mx, mx, mn, 0, 0, 0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 10, 0, 10, 5, 0, 0, 0);
    send_query(KIND_SEG_CIRCLE, 0, 0, 10, 0, 0, 0, 5, 3, 3, 0, 0);
    send_query(KIND_SEG_CIRCLE, 0, 0, 10, 0, 0, 0, -3, 4, 5, 0, 0);
    send_query(KIND_SEG_CIRCLE, 0, 0, 10, 0, 0, 0, 14, 3, 4, 0, 0);
    send_query(KIND_SEG_CIRCLE, 5, 5, 5, 5, 0, 0, 5, 5, 9, 0, 0);
    send_query(KIND_SEG_CIRCLE, mn, mn, mx, mx, 0, 0, mn, mx, '1, 0, 0);
    send_query(3'd7, mx, mn, mx, mn, mx, mn, mx, mn, '1, '1, '1);
    send_query(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    run_phase(23, 84, RANDOM_ITEMS / 3);
    run_phase(84, 23, RANDOM_ITEMS / 3);
    run_phase(0, 0, RANDOM_ITEMS / 3);
    recv_stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[collision_test_unit_2d_core] OK");
    end else begin
      $display("[collision_test_unit_2d_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== collision_test_unit_2d_core.f =====
src/ctu2d_pkg.sv
src/collision_test_unit_2d_core.sv
src/ctu2d_checker.sv
tb/ctu2d_checker.sv
tb/testbench.sv
